// File: design/sequence_reorder_buffer_core_macros.svh
// ----------------------------------------------------------------------------
// sequence reorder buffer assertion macros
// shared concurrent assertion forms, clocked on clk, reset on rst_n
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_CORE_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define SRB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SRB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// types and codes of the sequence reorder buffer
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int ID_W   = 31;
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;
    localparam int ST_W   = 3;
    localparam int ENT_W  = ID_W + DATA_W;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [ST_W-1:0] STAT_OK    = 3'd0;
    localparam logic [ST_W-1:0] STAT_DUP   = 3'd1;
    localparam logic [ST_W-1:0] STAT_FULL  = 3'd2;
    localparam logic [ST_W-1:0] STAT_ORDER = 3'd3;
    localparam logic [ST_W-1:0] STAT_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   seq_id;
        logic [DATA_W-1:0] entry_data;
    } req_word_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              front_valid;
        logic [ID_W-1:0]   front_id;
        logic [DATA_W-1:0] front_data;
        logic [OCC_W-1:0]  occupancy;
    } rsp_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_POP_WAIT,
        ST_FINISH
    } srb_state_t;

endpackage

// File: design/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram
// generic simple dual port ram, one write, one registered read
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/sequence_reorder_buffer_core.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_core
// bounded reorder buffer kept in id order, stored as a ring in one ram
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | word
//  req     | req_valid | req_stall | kind, seq_id, entry_data
//  rsp     | rsp_valid | rsp_stall | status, front, occupancy
//
//  append, pop of the last entry, edge inserts, rejects in idle: idle, then finish
//  pop with entries left: idle, pop wait (ram read of the new front), finish
//  middle insert: idle, scan reads up to the insert point, shift steps
//  moving entries up a slot, place, finish; scan rejects skip shift and place
//  reset empties the buffer at once, ram contents are never cleared
//  a stalled response holds the block in its finish state
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_core #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  srb_pkg::req_word_t req,
    input  logic              req_valid,
    output logic              req_stall,
    output srb_pkg::rsp_word_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_stall
);
    import srb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // logical index k to ram address, ring starts at head
    function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    srb_state_t state_reg, state_next;

    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [ID_W-1:0]   front_id_reg, front_id_next;
    logic [DATA_W-1:0] front_data_reg, front_data_next;
    logic [ID_W-1:0]   back_id_reg, back_id_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [ST_W-1:0]   status_reg, status_next;
    rsp_word_t         rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [ENT_W-1:0]  wdata, rdata;
    logic [ID_W-1:0]   rd_id;

    logic accept, full, empty, edge_dup, go_scan, go_pop_wait;
    logic scan_ge, scan_last, shift_last, rsp_free;

    srb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_id      = rdata[ENT_W-1:DATA_W];
    assign req_stall  = (state_reg != ST_IDLE);
    assign accept     = req_valid && !req_stall;
    assign full       = (count_reg == CW'(DEPTH));
    assign empty      = (count_reg == '0);
    assign edge_dup   = (req.seq_id == front_id_reg) || (req.seq_id == back_id_reg);
    // insert that falls strictly between front and back needs a scan
    assign go_scan    = (req.kind == KIND_INSERT) && !full && !empty && !edge_dup
                        && !(front_id_reg > req.seq_id) && !(back_id_reg < req.seq_id);
    assign go_pop_wait = (req.kind == KIND_POP) && (count_reg > CW'(1));
    assign scan_ge    = (rd_id >= id_reg);
    assign scan_last  = ((k_reg + CW'(1)) >= count_reg);
    assign shift_last = (j_reg == k_reg);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (go_scan)
                        state_next = ST_SCAN;
                    else if (go_pop_wait)
                        state_next = ST_POP_WAIT;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_ge)
                    state_next = (rd_id == id_reg) ? ST_FINISH : ST_SHIFT;
                else if (scan_last)
                    state_next = ST_FINISH;
            end
            ST_SHIFT:
            begin
                if (shift_last)
                    state_next = ST_PLACE;
            end
            ST_PLACE:    state_next = ST_FINISH;
            ST_POP_WAIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (rsp_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        front_id_next   = front_id_reg;
        front_data_next = front_data_reg;
        back_id_next    = back_id_reg;
        id_next         = id_reg;
        data_next       = data_reg;
        status_next     = status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        we              = 1'b0;
        waddr           = phys(head_reg, count_reg);
        wdata           = {req.seq_id, req.entry_data};
        raddr           = phys(head_reg, CW'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    id_next     = req.seq_id;
                    data_next   = req.entry_data;
                    status_next = STAT_OK;
                    case (req.kind)
                        KIND_APPEND, KIND_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (req.kind == KIND_INSERT && !empty && edge_dup)
                            begin
                                status_next = STAT_DUP;
                            end
                            else if (req.kind == KIND_INSERT && !empty
                                     && front_id_reg > req.seq_id)
                            begin
                                // new front, ring head steps back
                                head_next       = (head_reg == '0) ? AW'(DEPTH - 1)
                                                                   : head_reg - AW'(1);
                                we              = 1'b1;
                                waddr           = head_next;
                                front_id_next   = req.seq_id;
                                front_data_next = req.entry_data;
                                count_next      = count_reg + CW'(1);
                            end
                            else if (req.kind == KIND_APPEND || !go_scan)
                            begin
                                // plain append at the back
                                we           = 1'b1;
                                back_id_next = req.seq_id;
                                count_next   = count_reg + CW'(1);
                                if (empty)
                                begin
                                    front_id_next   = req.seq_id;
                                    front_data_next = req.entry_data;
                                end
                            end
                            else
                            begin
                                k_next = CW'(1);
                            end
                        end
                        KIND_POP:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                head_next  = phys(head_reg, CW'(1));
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_ge)
                begin
                    if (rd_id == id_reg)
                    begin
                        status_next = STAT_DUP;
                    end
                    else
                    begin
                        j_next = count_reg - CW'(1);
                        raddr  = phys(head_reg, count_reg - CW'(1));
                    end
                end
                else if (scan_last)
                begin
                    status_next = STAT_ORDER;
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                    raddr  = phys(head_reg, k_reg + CW'(1));
                end
            end
            ST_SHIFT:
            begin
                // entry j moves up one slot, read of j-1 overlaps
                we    = 1'b1;
                waddr = phys(head_reg, j_reg + CW'(1));
                wdata = rdata;
                if (!shift_last)
                begin
                    j_next = j_reg - CW'(1);
                    raddr  = phys(head_reg, j_reg - CW'(1));
                end
            end
            ST_PLACE:
            begin
                we         = 1'b1;
                waddr      = phys(head_reg, k_reg);
                wdata      = {id_reg, data_reg};
                count_next = count_reg + CW'(1);
            end
            ST_POP_WAIT:
            begin
                front_id_next   = rd_id;
                front_data_next = rdata[DATA_W-1:0];
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.front_valid = !empty;
                    rsp_next.front_id    = empty ? '0 : front_id_reg;
                    rsp_next.front_data  = empty ? '0 : front_data_reg;
                    rsp_next.occupancy   = OCC_W'(count_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        j_reg          <= j_next;
        front_id_reg   <= front_id_next;
        front_data_reg <= front_data_next;
        back_id_reg    <= back_id_next;
        id_reg         <= id_next;
        data_reg       <= data_next;
        status_reg     <= status_next;
        rsp_reg        <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `include "sequence_reorder_buffer_core_macros.svh"

    `SRB_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "occupancy above depth")
    `SRB_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE, "accept left block idle")
    `SRB_ASSERT_IMPL(a_shift_range, state_reg == ST_SHIFT,
                     j_reg >= k_reg && j_reg < count_reg, "shift index out of range")
    `SRB_ASSERT_IMPL(a_empty_front, rsp_valid && !rsp.front_valid,
                     rsp.front_id == '0 && rsp.occupancy == '0, "empty response with front")

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the sequence reorder buffer against a sorted-list predictor, with a
// directed table, random append/insert/pop traffic and random stalls
// ----------------------------------------------------------------------------
module tb;

    import srb_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [ID_W-1:0]   ID_MAX = {ID_W{1'b1}};
    localparam logic [DATA_W-1:0] D_MAX  = {DATA_W{1'b1}};

    logic      clk;
    logic      rst_n;
    req_word_t req;
    logic      req_valid;
    logic      req_stall;
    rsp_word_t rsp;
    logic      rsp_valid;
    logic      rsp_stall;

    sequence_reorder_buffer_core #(.DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .req(req), .req_valid(req_valid), .req_stall(req_stall),
        .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
    );

    // predictor copy of the buffer
    logic [ID_W-1:0]   buf_ids[DEPTH];
    logic [DATA_W-1:0] buf_words[DEPTH];
    int                buf_count;

    rsp_word_t pending_rsp[$];
    int        fail_count;
    bit        hold_rx;

    // directed table
    typedef struct {
        req_word_t word;
        bit        has_exp;
        rsp_word_t exp;
    } dir_row_t;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // put one entry at pos, shifting the tail back
    function automatic void place_entry(int pos, logic [ID_W-1:0] id, logic [DATA_W-1:0] w);
        for (int i = buf_count; i > pos; i--)
        begin
            buf_ids[i]   = buf_ids[i-1];
            buf_words[i] = buf_words[i-1];
        end
        buf_ids[pos]   = id;
        buf_words[pos] = w;
        buf_count++;
    endfunction

    function automatic logic [ST_W-1:0] sorted_insert(logic [ID_W-1:0] id, logic [DATA_W-1:0] w);
        int p;
        if (buf_count == 0)
        begin
            place_entry(0, id, w);
            return STAT_OK;
        end
        if (buf_ids[0] == id || buf_ids[buf_count-1] == id)
            return STAT_DUP;
        if (buf_ids[0] > id)
        begin
            place_entry(0, id, w);
            return STAT_OK;
        end
        if (buf_ids[buf_count-1] < id)
        begin
            place_entry(buf_count, id, w);
            return STAT_OK;
        end
        p = 0;
        while (p + 1 < buf_count && buf_ids[p+1] < id)
            p++;
        // scan ran off the end: list out of order after an append
        if (p + 1 >= buf_count)
            return STAT_ORDER;
        if (buf_ids[p+1] == id)
            return STAT_DUP;
        place_entry(p + 1, id, w);
        return STAT_OK;
    endfunction

    function automatic rsp_word_t buffer_step(req_word_t r);
        rsp_word_t o;
        o = '0;
        o.status = STAT_OK;
        if (r.kind == KIND_APPEND)
        begin
            if (buf_count >= DEPTH)
                o.status = STAT_FULL;
            else
                place_entry(buf_count, r.seq_id, r.entry_data);
        end
        else if (r.kind == KIND_INSERT)
        begin
            if (buf_count >= DEPTH)
                o.status = STAT_FULL;
            else
                o.status = sorted_insert(r.seq_id, r.entry_data);
        end
        else if (r.kind == KIND_POP)
        begin
            if (buf_count == 0)
                o.status = STAT_EMPTY;
            else
            begin
                for (int i = 0; i + 1 < buf_count; i++)
                begin
                    buf_ids[i]   = buf_ids[i+1];
                    buf_words[i] = buf_words[i+1];
                end
                buf_count--;
            end
        end
        if (buf_count > 0)
        begin
            o.front_valid = 1'b1;
            o.front_id    = buf_ids[0];
            o.front_data  = buf_words[0];
        end
        o.occupancy = buf_count[OCC_W-1:0];
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        case ($urandom_range(0, 3))
            0: return ID_W'($urandom_range(0, 40));
            1: return ID_W'($urandom());
            2: return ID_MAX - ID_W'($urandom_range(0, 3));
            default: return ID_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // one word through the handshake; expectation computed on acceptance
    task automatic send_word(req_word_t w, bit has_exp, rsp_word_t exp);
        rsp_word_t pred;
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = buffer_step(w);
        if (has_exp && pred !== exp)
        begin
            $error("directed row predicted %h, table says %h", pred, exp);
            fail_count++;
        end
        pending_rsp.push_back(pred);
    endtask

    task automatic idle_sender(int n);
        if (n > 0)
        begin
            req_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic rsp_word_t mk_rsp(logic [ST_W-1:0] s, logic fv,
                                         logic [ID_W-1:0] id, logic [DATA_W-1:0] d, int occ);
        rsp_word_t o;
        o.status      = s;
        o.front_valid = fv;
        o.front_id    = id;
        o.front_data  = d;
        o.occupancy   = occ[OCC_W-1:0];
        return o;
    endfunction

    function automatic req_word_t mk_req(logic [1:0] k, logic [ID_W-1:0] id, logic [DATA_W-1:0] d);
        req_word_t r;
        r.kind       = k;
        r.seq_id     = id;
        r.entry_data = d;
        return r;
    endfunction

    // receiver stalls, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= ($urandom_range(0, 3) == 0);
    end

    // compare each response with the oldest expectation
    always @(posedge clk)
    begin
        rsp_word_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing expected: %h", rsp);
                fail_count++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    fail_count++;
                end
                if (rsp.front_valid !== e.front_valid)
                begin
                    $error("front_valid exp %0d got %0d", e.front_valid, rsp.front_valid);
                    fail_count++;
                end
                if (rsp.front_id !== e.front_id)
                begin
                    $error("front_id exp %h got %h", e.front_id, rsp.front_id);
                    fail_count++;
                end
                if (rsp.front_data !== e.front_data)
                begin
                    $error("front_data exp %h got %h", e.front_data, rsp.front_data);
                    fail_count++;
                end
                if (rsp.occupancy !== e.occupancy)
                begin
                    $error("occupancy exp %0d got %0d", e.occupancy, rsp.occupancy);
                    fail_count++;
                end
            end
        end
    end

    // long receiver hold-off so the buffer backs up into the request side
    initial
    begin
        hold_rx = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_rx = 1'b1;
        repeat (400) @(posedge clk);
        hold_rx = 1'b0;
    end

    initial
    begin
        #8000000;
        $display("[sequence_reorder_buffer_core] ERROR");
        $finish;
    end

    initial
    begin
        dir_row_t          rows[$];
        dir_row_t          row;
        rsp_word_t         none;
        req_word_t         w;
        logic [ID_W-1:0]   base;
        int                burst;
        int                r;

        none       = '0;
        fail_count = 0;
        buf_count  = 0;
        rst_n      = 1'b0;
        req        = '0;
        req_valid  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pop on empty, extremes, dup at front, back and middle, unused kind, full
        rows.push_back('{mk_req(KIND_POP, 0, 0), 1, mk_rsp(STAT_EMPTY, 0, 0, 0, 0)});
        rows.push_back('{mk_req(KIND_INSERT, ID_MAX, D_MAX), 1,
                         mk_rsp(STAT_OK, 1, ID_MAX, D_MAX, 1)});
        rows.push_back('{mk_req(KIND_INSERT, 0, 0), 1, mk_rsp(STAT_OK, 1, 0, 0, 2)});
        rows.push_back('{mk_req(KIND_INSERT, 0, 5), 1, mk_rsp(STAT_DUP, 1, 0, 0, 2)});
        rows.push_back('{mk_req(KIND_INSERT, ID_MAX, 5), 1, mk_rsp(STAT_DUP, 1, 0, 0, 2)});
        rows.push_back('{mk_req(KIND_INSERT, 100, 32'h5555_aaaa), 0, none});
        rows.push_back('{mk_req(KIND_INSERT, 100, 1), 1, mk_rsp(STAT_DUP, 1, 0, 0, 3)});
        rows.push_back('{mk_req(KIND_INSERT, 50, 32'haaaa_5555), 0, none});
        rows.push_back('{mk_req(KIND_APPEND, 10, 7), 0, none});
        rows.push_back('{mk_req(KIND_INSERT, 10, 3), 1, mk_rsp(STAT_DUP, 1, 0, 0, 5)});
        rows.push_back('{mk_req(KIND_NONE, ID_MAX, D_MAX), 1, mk_rsp(STAT_OK, 1, 0, 0, 5)});
        rows.push_back('{mk_req(KIND_POP, 0, 0), 0, none});
        for (int i = 0; i < 12; i++)
            rows.push_back('{mk_req(KIND_APPEND, 200 + i, i), 0, none});
        rows.push_back('{mk_req(KIND_INSERT, 3, 3), 1, mk_rsp(STAT_FULL, 1, 50, 32'haaaa_5555, 16)});
        foreach (rows[i])
        begin
            row = rows[i];
            send_word(row.word, row.has_exp, row.exp);
        end
        // drain to empty
        while (buf_count > 0)
            send_word(mk_req(KIND_POP, 0, 0), 0, none);

        // random traffic: sorted inserts in windows, some appends and pops
        r = 0;
        while (r < 1450)
        begin
            base  = rand_id();
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++)
            begin
                case ($urandom_range(0, 9))
                    0: w.kind = KIND_APPEND;
                    1, 2, 3: w.kind = KIND_POP;
                    4: w.kind = KIND_NONE;
                    default: w.kind = KIND_INSERT;
                endcase
                if ($urandom_range(0, 3) == 0)
                    w.seq_id = rand_id();
                else
                    w.seq_id = base + ID_W'($urandom_range(0, 30));
                w.entry_data = $urandom();
                send_word(w, 0, none);
                idle_sender(gap_len());
                r++;
            end
            // when a burst ends between words 700 and 730, pause until everything has come back
            if (r > 700 && r < 730)
            begin
                idle_sender(1);
                wait (pending_rsp.size() == 0);
                @(posedge clk);
            end
        end
        req_valid <= 1'b0;

        wait (pending_rsp.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("[sequence_reorder_buffer_core] OK");
        else
            $display("[sequence_reorder_buffer_core] ERROR");
        $finish;
    end

endmodule
